[src/incremental_step_distance_correlation_core_defines.svh]
// ---------------------------------------------------------------------------
// Step-distance correlation core: assertion macros
// Shared concurrent assertion forms used by the checker.
// ---------------------------------------------------------------------------
`ifndef INCREMENTAL_STEP_DISTANCE_CORRELATION_CORE_DEFINES_SVH
`define INCREMENTAL_STEP_DISTANCE_CORRELATION_CORE_DEFINES_SVH

// same-cycle implication
`define ISDC_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ISDC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/isdc_pkg.sv]
// ---------------------------------------------------------------------------
// Step-distance correlation: shared package
// Widths, payload structs, datapath command codes and control structs.
// ---------------------------------------------------------------------------
`default_nettype none

package isdc_pkg;

   localparam int COORD_BITS = 20;
   localparam int MAX_POINTS = 64;
   localparam int PTS_W      = $clog2(MAX_POINTS + 1);
   localparam int COUNT_W    = 7;
   localparam int STEP_W     = COORD_BITS + 1;
   localparam int SUM_STEP_W = 40;
   localparam int SUM_W      = 64;
   localparam int FRAC_BITS  = 14;
   localparam int CORR_W     = 16;
   localparam int CORR_ONE   = 1 << FRAC_BITS;
   localparam int WIDE_W     = 2 * SUM_STEP_W + FRAC_BITS + 2;
   localparam int MUL_W      = 32;
   localparam int RAD_W      = 64;
   localparam int ROOT_W     = RAD_W / 2;
   localparam int NORM_TOP   = RAD_W - 2;
   localparam int SQ_ITER_W  = $clog2(ROOT_W);
   localparam int SH_W       = $clog2(WIDE_W);
   localparam int DIV_W      = $clog2(FRAC_BITS + 1);
   localparam int OP_W       = 5;
   localparam int IDX_W      = 3;

   localparam logic [OP_W-1:0] OP_NOP          = 5'd0;
   localparam logic [OP_W-1:0] OP_CAPTURE      = 5'd1;
   localparam logic [OP_W-1:0] OP_START        = 5'd2;
   localparam logic [OP_W-1:0] OP_FULL         = 5'd3;
   localparam logic [OP_W-1:0] OP_SQX          = 5'd4;
   localparam logic [OP_W-1:0] OP_SQY          = 5'd5;
   localparam logic [OP_W-1:0] OP_RT_LOAD_STEP = 5'd6;
   localparam logic [OP_W-1:0] OP_RT_RUN       = 5'd7;
   localparam logic [OP_W-1:0] OP_KEEP_STEP    = 5'd8;
   localparam logic [OP_W-1:0] OP_PROD         = 5'd9;
   localparam logic [OP_W-1:0] OP_ACC          = 5'd10;
   localparam logic [OP_W-1:0] OP_MUL_LOAD     = 5'd11;
   localparam logic [OP_W-1:0] OP_MUL_RUN      = 5'd12;
   localparam logic [OP_W-1:0] OP_KEEP_W1      = 5'd13;
   localparam logic [OP_W-1:0] OP_VAR          = 5'd14;
   localparam logic [OP_W-1:0] OP_NORM         = 5'd15;
   localparam logic [OP_W-1:0] OP_RT_LOAD_WIDE = 5'd16;
   localparam logic [OP_W-1:0] OP_KEEP_ROOT    = 5'd17;
   localparam logic [OP_W-1:0] OP_NUM          = 5'd18;
   localparam logic [OP_W-1:0] OP_DMUL         = 5'd19;
   localparam logic [OP_W-1:0] OP_SCALE        = 5'd20;
   localparam logic [OP_W-1:0] OP_DIV_SAT      = 5'd21;
   localparam logic [OP_W-1:0] OP_DIV_RUN      = 5'd22;
   localparam logic [OP_W-1:0] OP_EMIT         = 5'd23;

   // step product selects
   localparam logic [IDX_W-1:0] PROD_CROSS = 3'd0;
   localparam logic [IDX_W-1:0] PROD_LAND  = 3'd1;
   localparam logic [IDX_W-1:0] PROD_PLAN  = 3'd2;

   // wide product selects, in evaluation order
   localparam logic [IDX_W-1:0] MUL_N_LQ  = 3'd0;
   localparam logic [IDX_W-1:0] MUL_LS_LS = 3'd1;
   localparam logic [IDX_W-1:0] MUL_N_PQ  = 3'd2;
   localparam logic [IDX_W-1:0] MUL_PS_PS = 3'd3;
   localparam logic [IDX_W-1:0] MUL_N_CR  = 3'd4;
   localparam logic [IDX_W-1:0] MUL_LS_PS = 3'd5;

   typedef struct packed {
      logic                         action;
      logic signed [COORD_BITS-1:0] landmark_x;
      logic signed [COORD_BITS-1:0] landmark_y;
      logic signed [COORD_BITS-1:0] floor_x;
      logic signed [COORD_BITS-1:0] floor_y;
   } req_type;

   typedef struct packed {
      logic signed [CORR_W-1:0] corr_value;
      logic                     corr_defined;
      logic                     passes_threshold;
      logic [COUNT_W-1:0]       point_count;
      logic                     saturated;
   } rsp_type;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [IDX_W-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic is_start;
      logic is_full;
      logic rt_last;
      logic mul_done;
      logic var_pos;
      logic norm_done;
      logic div_big;
      logic div_last;
      logic rsp_busy;
   } status_type;

endpackage

`default_nettype wire

[src/isdc_dp.sv]
// ---------------------------------------------------------------------------
// Step-distance correlation: datapath
// Chain state, running sums, shared 32x32 multiplier, bit-serial wide
// multiplier, square-root unit, restoring divider and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module isdc_dp import isdc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  req_type           req_data,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic              csr_wr_en,
   input  logic [CORR_W-1:0] csr_wr_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data
);

   req_type                 in_ff;
   logic [COORD_BITS-1:0]   prev_lx_ff, prev_ly_ff, prev_px_ff, prev_py_ff;
   logic [PTS_W-1:0]        pts_ff;
   logic [SUM_STEP_W-1:0]   sum_ls_ff, sum_ps_ff;
   logic [SUM_W-1:0]        sum_cr_ff, sum_lq_ff, sum_pq_ff;
   logic                    sat_ff;
   logic [STEP_W-1:0]       dl_ff, dp_ff;
   logic [2*STEP_W-1:0]     cross_ff, lsq_ff, psq_ff;
   logic [2*MUL_W-1:0]      prod_ff, rad_ff, d_ff;
   logic [RAD_W-1:0]        sv_ff, sr_ff;
   logic [SQ_ITER_W-1:0]    sk_ff;
   logic [WIDE_W-1:0]       ma_ff, macc_ff, w1_ff, m_ff;
   logic [SUM_STEP_W-1:0]   mb_ff;
   logic [SH_W-1:0]         nj_ff, s_ff;
   logic [ROOT_W-1:0]       sa_ff, sb_ff;
   logic                    neg_ff;
   logic [CORR_W-1:0]       res_ff;
   logic [DIV_W-1:0]        dk_ff;
   logic [CORR_W-1:0]       min_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff;

   logic [STEP_W-1:0]       dx_in, dy_in, ax_in, ay_in;
   logic [MUL_W-1:0]        mx_in, my_in;
   logic [2*MUL_W-1:0]      mp_in;
   logic [RAD_W-1:0]        bit_in, trial_in;
   logic                    sq_ge_in;
   logic [SUM_STEP_W:0]     nls_in, nps_in;
   logic [SUM_W:0]          ncr_in, nlq_in, npq_in;
   logic [WIDE_W-1:0]       dt_in, dbig_in;
   logic [WIDE_W+FRAC_BITS-1:0] sc_in;
   logic [CORR_W-1:0]       mag_in;
   logic signed [CORR_W:0]  cv_in;
   logic                    pass_in;

   // step differences, land or plan side
   always_comb begin
      if (cmd.idx[0] == 1'b0) begin
         dx_in = {in_ff.landmark_x[COORD_BITS-1], in_ff.landmark_x}
               - {prev_lx_ff[COORD_BITS-1], prev_lx_ff};
         dy_in = {in_ff.landmark_y[COORD_BITS-1], in_ff.landmark_y}
               - {prev_ly_ff[COORD_BITS-1], prev_ly_ff};
      end else begin
         dx_in = {in_ff.floor_x[COORD_BITS-1], in_ff.floor_x}
               - {prev_px_ff[COORD_BITS-1], prev_px_ff};
         dy_in = {in_ff.floor_y[COORD_BITS-1], in_ff.floor_y}
               - {prev_py_ff[COORD_BITS-1], prev_py_ff};
      end
      ax_in = dx_in[STEP_W-1] ? (~dx_in + STEP_W'(1)) : dx_in;
      ay_in = dy_in[STEP_W-1] ? (~dy_in + STEP_W'(1)) : dy_in;
   end

   // shared combinational multiplier
   always_comb begin
      mx_in = '0;
      my_in = '0;
      case (cmd.op)
         OP_SQX: begin
            mx_in = MUL_W'(ax_in);
            my_in = MUL_W'(ax_in);
         end
         OP_SQY: begin
            mx_in = MUL_W'(ay_in);
            my_in = MUL_W'(ay_in);
         end
         OP_PROD: begin
            case (cmd.idx)
               PROD_CROSS: begin
                  mx_in = MUL_W'(dl_ff);
                  my_in = MUL_W'(dp_ff);
               end
               PROD_LAND: begin
                  mx_in = MUL_W'(dl_ff);
                  my_in = MUL_W'(dl_ff);
               end
               default: begin
                  mx_in = MUL_W'(dp_ff);
                  my_in = MUL_W'(dp_ff);
               end
            endcase
         end
         OP_DMUL: begin
            mx_in = sa_ff;
            my_in = sb_ff;
         end
         default: begin
            mx_in = '0;
            my_in = '0;
         end
      endcase
   end

   assign mp_in    = mx_in * my_in;

   assign bit_in   = RAD_W'(1) << {sk_ff, 1'b0};
   assign trial_in = sr_ff + bit_in;
   assign sq_ge_in = sv_ff >= trial_in;

   assign nls_in = {1'b0, sum_ls_ff} + (SUM_STEP_W+1)'(dl_ff);
   assign nps_in = {1'b0, sum_ps_ff} + (SUM_STEP_W+1)'(dp_ff);
   assign ncr_in = {1'b0, sum_cr_ff} + (SUM_W+1)'(cross_ff);
   assign nlq_in = {1'b0, sum_lq_ff} + (SUM_W+1)'(lsq_ff);
   assign npq_in = {1'b0, sum_pq_ff} + (SUM_W+1)'(psq_ff);

   assign sc_in   = {w1_ff, FRAC_BITS'(0)} >> s_ff;
   assign dt_in   = WIDE_W'(d_ff) << dk_ff;
   assign dbig_in = WIDE_W'(d_ff) << (FRAC_BITS + 1);

   always_comb begin
      mag_in  = (res_ff > CORR_W'(CORR_ONE)) ? CORR_W'(CORR_ONE) : res_ff;
      cv_in   = neg_ff ? -$signed({1'b0, mag_in}) : $signed({1'b0, mag_in});
      pass_in = cv_in >= $signed({min_ff[CORR_W-1], min_ff});
   end

   assign status.is_start  = (in_ff.action == 1'b0) || (pts_ff == '0);
   assign status.is_full   = pts_ff >= PTS_W'(MAX_POINTS);
   assign status.rt_last   = sk_ff == '0;
   assign status.mul_done  = mb_ff == '0;
   assign status.var_pos   = w1_ff > macc_ff;
   assign status.norm_done = w1_ff[WIDE_W-1:NORM_TOP] == '0;
   assign status.div_big   = m_ff >= dbig_in;
   assign status.div_last  = dk_ff == '0;
   assign status.rsp_busy  = rsp_valid_ff && !rsp_ready;

   // chain state, threshold and result handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_lx_ff   <= '0;
         prev_ly_ff   <= '0;
         prev_px_ff   <= '0;
         prev_py_ff   <= '0;
         pts_ff       <= '0;
         sum_ls_ff    <= '0;
         sum_ps_ff    <= '0;
         sum_cr_ff    <= '0;
         sum_lq_ff    <= '0;
         sum_pq_ff    <= '0;
         min_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            min_ff <= csr_wr_data;
         end
         if (cmd.op == OP_EMIT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd.op)
            OP_START: begin
               prev_lx_ff <= in_ff.landmark_x;
               prev_ly_ff <= in_ff.landmark_y;
               prev_px_ff <= in_ff.floor_x;
               prev_py_ff <= in_ff.floor_y;
               pts_ff     <= PTS_W'(1);
               sum_ls_ff  <= '0;
               sum_ps_ff  <= '0;
               sum_cr_ff  <= '0;
               sum_lq_ff  <= '0;
               sum_pq_ff  <= '0;
            end
            OP_ACC: begin
               prev_lx_ff <= in_ff.landmark_x;
               prev_ly_ff <= in_ff.landmark_y;
               prev_px_ff <= in_ff.floor_x;
               prev_py_ff <= in_ff.floor_y;
               pts_ff     <= pts_ff + PTS_W'(1);
               sum_ls_ff  <= nls_in[SUM_STEP_W] ? '1 : nls_in[SUM_STEP_W-1:0];
               sum_ps_ff  <= nps_in[SUM_STEP_W] ? '1 : nps_in[SUM_STEP_W-1:0];
               sum_cr_ff  <= ncr_in[SUM_W] ? '1 : ncr_in[SUM_W-1:0];
               sum_lq_ff  <= nlq_in[SUM_W] ? '1 : nlq_in[SUM_W-1:0];
               sum_pq_ff  <= npq_in[SUM_W] ? '1 : npq_in[SUM_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_CAPTURE: begin
            in_ff  <= req_data;
            sat_ff <= 1'b0;
         end
         OP_START: begin
            sat_ff <= 1'b0;
         end
         OP_FULL: begin
            sat_ff <= 1'b1;
         end
         OP_SQX: begin
            prod_ff <= mp_in;
         end
         OP_SQY: begin
            rad_ff  <= prod_ff;
            prod_ff <= mp_in;
         end
         OP_RT_LOAD_STEP: begin
            sv_ff <= rad_ff + prod_ff;
            sr_ff <= '0;
            sk_ff <= '1;
         end
         OP_RT_RUN: begin
            if (sq_ge_in) begin
               sv_ff <= sv_ff - trial_in;
               sr_ff <= (sr_ff >> 1) + bit_in;
            end else begin
               sr_ff <= sr_ff >> 1;
            end
            sk_ff <= sk_ff - SQ_ITER_W'(1);
         end
         OP_KEEP_STEP: begin
            if (cmd.idx[0] == 1'b0) begin
               dl_ff <= sr_ff[STEP_W-1:0];
            end else begin
               dp_ff <= sr_ff[STEP_W-1:0];
            end
         end
         OP_PROD: begin
            case (cmd.idx)
               PROD_CROSS: cross_ff <= mp_in[2*STEP_W-1:0];
               PROD_LAND:  lsq_ff   <= mp_in[2*STEP_W-1:0];
               default:    psq_ff   <= mp_in[2*STEP_W-1:0];
            endcase
         end
         OP_ACC: begin
            sat_ff <= nls_in[SUM_STEP_W] | nps_in[SUM_STEP_W] | ncr_in[SUM_W]
                    | nlq_in[SUM_W] | npq_in[SUM_W];
         end
         OP_MUL_LOAD: begin
            macc_ff <= '0;
            case (cmd.idx)
               MUL_N_LQ: begin
                  ma_ff <= WIDE_W'(sum_lq_ff);
                  mb_ff <= SUM_STEP_W'(pts_ff);
               end
               MUL_LS_LS: begin
                  ma_ff <= WIDE_W'(sum_ls_ff);
                  mb_ff <= sum_ls_ff;
               end
               MUL_N_PQ: begin
                  ma_ff <= WIDE_W'(sum_pq_ff);
                  mb_ff <= SUM_STEP_W'(pts_ff);
               end
               MUL_PS_PS: begin
                  ma_ff <= WIDE_W'(sum_ps_ff);
                  mb_ff <= sum_ps_ff;
               end
               MUL_N_CR: begin
                  ma_ff <= WIDE_W'(sum_cr_ff);
                  mb_ff <= SUM_STEP_W'(pts_ff);
               end
               default: begin
                  ma_ff <= WIDE_W'(sum_ls_ff);
                  mb_ff <= sum_ps_ff;
               end
            endcase
         end
         OP_MUL_RUN: begin
            if (mb_ff != '0) begin
               if (mb_ff[0]) begin
                  macc_ff <= macc_ff + ma_ff;
               end
               ma_ff <= ma_ff << 1;
               mb_ff <= mb_ff >> 1;
            end
         end
         OP_KEEP_W1: begin
            w1_ff <= macc_ff;
         end
         OP_VAR: begin
            w1_ff <= w1_ff - macc_ff;
            nj_ff <= '0;
         end
         OP_NORM: begin
            if (w1_ff[WIDE_W-1:NORM_TOP] != '0) begin
               w1_ff <= w1_ff >> 2;
               nj_ff <= nj_ff + SH_W'(1);
            end
         end
         OP_RT_LOAD_WIDE: begin
            sv_ff <= w1_ff[RAD_W-1:0];
            sr_ff <= '0;
            sk_ff <= '1;
         end
         OP_KEEP_ROOT: begin
            if (cmd.idx[0] == 1'b0) begin
               sa_ff <= sr_ff[ROOT_W-1:0];
               s_ff  <= nj_ff;
            end else begin
               sb_ff <= sr_ff[ROOT_W-1:0];
               s_ff  <= s_ff + nj_ff;
            end
         end
         OP_NUM: begin
            neg_ff <= w1_ff < macc_ff;
            w1_ff  <= (w1_ff < macc_ff) ? (macc_ff - w1_ff) : (w1_ff - macc_ff);
         end
         OP_DMUL: begin
            d_ff <= mp_in;
         end
         OP_SCALE: begin
            m_ff   <= sc_in[WIDE_W-1:0];
            res_ff <= '0;
            dk_ff  <= DIV_W'(FRAC_BITS);
         end
         OP_DIV_SAT: begin
            res_ff <= CORR_W'(CORR_ONE);
         end
         OP_DIV_RUN: begin
            if (m_ff >= dt_in) begin
               m_ff   <= m_ff - dt_in;
               res_ff <= res_ff | (CORR_W'(1) << dk_ff);
            end
            dk_ff <= dk_ff - DIV_W'(1);
         end
         OP_EMIT: begin
            rsp_ff.point_count <= COUNT_W'(pts_ff);
            rsp_ff.saturated   <= sat_ff;
            if (cmd.idx[0]) begin
               rsp_ff.corr_value       <= cv_in[CORR_W-1:0];
               rsp_ff.corr_defined     <= 1'b1;
               rsp_ff.passes_threshold <= pass_in;
            end else begin
               rsp_ff.corr_value       <= '0;
               rsp_ff.corr_defined     <= 1'b0;
               rsp_ff.passes_threshold <= 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

[src/isdc_ctrl.sv]
// ---------------------------------------------------------------------------
// Step-distance correlation: controller
// Sequences step measurement, sum update and the correlation evaluation.
// ---------------------------------------------------------------------------
`default_nettype none

module isdc_ctrl import isdc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_DECIDE = 5'd1;
   localparam logic [4:0] S_SQX    = 5'd2;
   localparam logic [4:0] S_SQY    = 5'd3;
   localparam logic [4:0] S_RTLD   = 5'd4;
   localparam logic [4:0] S_RTRUN  = 5'd5;
   localparam logic [4:0] S_KEEP   = 5'd6;
   localparam logic [4:0] S_PROD0  = 5'd7;
   localparam logic [4:0] S_PROD1  = 5'd8;
   localparam logic [4:0] S_PROD2  = 5'd9;
   localparam logic [4:0] S_ACC    = 5'd10;
   localparam logic [4:0] S_MLD    = 5'd11;
   localparam logic [4:0] S_MRUN   = 5'd12;
   localparam logic [4:0] S_KEEPW  = 5'd13;
   localparam logic [4:0] S_VAR    = 5'd14;
   localparam logic [4:0] S_NORM   = 5'd15;
   localparam logic [4:0] S_RTWL   = 5'd16;
   localparam logic [4:0] S_RTRUN2 = 5'd17;
   localparam logic [4:0] S_KEEPR  = 5'd18;
   localparam logic [4:0] S_NUM    = 5'd19;
   localparam logic [4:0] S_DMUL   = 5'd20;
   localparam logic [4:0] S_SCALE  = 5'd21;
   localparam logic [4:0] S_DCHK   = 5'd22;
   localparam logic [4:0] S_DIV    = 5'd23;
   localparam logic [4:0] S_EMIT   = 5'd24;

   logic [4:0]       state_ff, state_in;
   logic             side_ff, side_in;
   logic [IDX_W-1:0] mi_ff, mi_in;
   logic             def_ff, def_in;

   always_comb begin
      state_in  = state_ff;
      side_in   = side_ff;
      mi_in     = mi_ff;
      def_in    = def_ff;
      req_ready = 1'b0;
      cmd.op    = OP_NOP;
      cmd.idx   = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_CAPTURE;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            side_in = 1'b0;
            mi_in   = MUL_N_LQ;
            if (status.is_start) begin
               cmd.op   = OP_START;
               state_in = S_MLD;
            end else if (status.is_full) begin
               cmd.op   = OP_FULL;
               state_in = S_MLD;
            end else begin
               state_in = S_SQX;
            end
         end
         S_SQX: begin
            cmd.op   = OP_SQX;
            cmd.idx  = IDX_W'(side_ff);
            state_in = S_SQY;
         end
         S_SQY: begin
            cmd.op   = OP_SQY;
            cmd.idx  = IDX_W'(side_ff);
            state_in = S_RTLD;
         end
         S_RTLD: begin
            cmd.op   = OP_RT_LOAD_STEP;
            state_in = S_RTRUN;
         end
         S_RTRUN: begin
            cmd.op = OP_RT_RUN;
            if (status.rt_last) begin
               state_in = S_KEEP;
            end
         end
         S_KEEP: begin
            cmd.op  = OP_KEEP_STEP;
            cmd.idx = IDX_W'(side_ff);
            if (!side_ff) begin
               side_in  = 1'b1;
               state_in = S_SQX;
            end else begin
               state_in = S_PROD0;
            end
         end
         S_PROD0: begin
            cmd.op   = OP_PROD;
            cmd.idx  = PROD_CROSS;
            state_in = S_PROD1;
         end
         S_PROD1: begin
            cmd.op   = OP_PROD;
            cmd.idx  = PROD_LAND;
            state_in = S_PROD2;
         end
         S_PROD2: begin
            cmd.op   = OP_PROD;
            cmd.idx  = PROD_PLAN;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.op   = OP_ACC;
            state_in = S_MLD;
         end
         S_MLD: begin
            cmd.op   = OP_MUL_LOAD;
            cmd.idx  = mi_ff;
            state_in = S_MRUN;
         end
         S_MRUN: begin
            cmd.op = OP_MUL_RUN;
            if (status.mul_done) begin
               case (mi_ff)
                  MUL_LS_LS, MUL_PS_PS: state_in = S_VAR;
                  MUL_LS_PS:            state_in = S_NUM;
                  default:              state_in = S_KEEPW;
               endcase
            end
         end
         S_KEEPW: begin
            cmd.op   = OP_KEEP_W1;
            mi_in    = mi_ff + IDX_W'(1);
            state_in = S_MLD;
         end
         S_VAR: begin
            if (status.var_pos) begin
               cmd.op   = OP_VAR;
               state_in = S_NORM;
            end else begin
               def_in   = 1'b0;
               state_in = S_EMIT;
            end
         end
         S_NORM: begin
            cmd.op = OP_NORM;
            if (status.norm_done) begin
               state_in = S_RTWL;
            end
         end
         S_RTWL: begin
            cmd.op   = OP_RT_LOAD_WIDE;
            state_in = S_RTRUN2;
         end
         S_RTRUN2: begin
            cmd.op = OP_RT_RUN;
            if (status.rt_last) begin
               state_in = S_KEEPR;
            end
         end
         S_KEEPR: begin
            cmd.op   = OP_KEEP_ROOT;
            cmd.idx  = IDX_W'(mi_ff == MUL_PS_PS);
            mi_in    = mi_ff + IDX_W'(1);
            state_in = S_MLD;
         end
         S_NUM: begin
            cmd.op   = OP_NUM;
            state_in = S_DMUL;
         end
         S_DMUL: begin
            cmd.op   = OP_DMUL;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            cmd.op   = OP_SCALE;
            state_in = S_DCHK;
         end
         S_DCHK: begin
            def_in = 1'b1;
            if (status.div_big) begin
               cmd.op   = OP_DIV_SAT;
               state_in = S_EMIT;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.op = OP_DIV_RUN;
            if (status.div_last) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!status.rsp_busy) begin
               cmd.op   = OP_EMIT;
               cmd.idx  = IDX_W'(def_ff);
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         side_ff  <= 1'b0;
         mi_ff    <= '0;
         def_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         side_ff  <= side_in;
         mi_ff    <= mi_in;
         def_ff   <= def_in;
      end
   end

endmodule

`default_nettype wire

[src/incremental_step_distance_correlation_core.sv]
// ---------------------------------------------------------------------------
// Step-distance correlation core
// Running Pearson correlation of landmark and floor-plan step distances.
// ---------------------------------------------------------------------------
// Usage:
//   req_*: one item per transfer (start or append, a landmark point and a
//   floor-plan point). rsp_*: exactly one result per item, in order.
//   csr_wr_en/csr_wr_data: correlation threshold, written while idle.
// Flow: one item is processed at a time. The processing time is set by the
//   shared 32-step square-root unit (up to four passes on an append) and
//   the bit-serial wide multiplier (one multiplier bit per cycle, up to 40
//   bits, up to six products per item). The next transfer can follow once a
//   result is registered; req_ready is high only while the core waits for
//   an item.
// Output: the result sits in an output register; the next item is accepted
//   while it waits. If the receiver stalls, a finished second result waits
//   inside the core until the register frees.
// Reset: synchronous; clears the chain, all sums and the threshold.
// ---------------------------------------------------------------------------
`default_nettype none

module incremental_step_distance_correlation_core import isdc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_wr_en,
   input  logic [CORR_W-1:0] csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   isdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   isdc_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .cmd         (cmd),
      .status      (status),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

[src/isdc_checker.sv]
// ---------------------------------------------------------------------------
// Step-distance correlation: port checker
// Port-level properties of the core, attached by bind.
// ---------------------------------------------------------------------------
`default_nettype none

`include "incremental_step_distance_correlation_core_defines.svh"

module isdc_checker import isdc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   `ISDC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "rsp changed while stalled")
   `ISDC_ASSERT_NEXT(a_busy_after_transfer, req_valid && req_ready, !req_ready, "req_ready stayed high after a transfer")
   `ISDC_ASSERT_IMPLY(a_undef_zero, rsp_valid && !rsp_data.corr_defined, rsp_data.corr_value == '0 && !rsp_data.passes_threshold, "undefined result not cleared")
   `ISDC_ASSERT_IMPLY(a_count_range, rsp_valid, rsp_data.point_count != '0 && rsp_data.point_count <= MAX_POINTS, "point count out of range")
   `ISDC_ASSERT_IMPLY(a_corr_range, rsp_valid && rsp_data.corr_defined, $signed(rsp_data.corr_value) <= CORR_ONE && $signed(rsp_data.corr_value) >= -CORR_ONE, "correlation out of range")

endmodule

bind incremental_step_distance_correlation_core isdc_checker u_isdc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

[tb/testbench.sv]
// ---------------------------------------------------------------------------
// Step-distance correlation core testbench
// Drives start and append items with random coordinates, predicts every
// result with an independent model of the running sums and the correlation,
// and compares each result field by field, under varying idle and stall
// patterns and several threshold settings.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module testbench;
   import isdc_pkg::*;

   localparam int SETTLE_CYCLES = 400;

   class corr_scoreboard;
      rsp_type              expected_q[$];
      int                   errors;
      logic signed [15:0]   min_corr;
      longint               prev_lx, prev_ly, prev_fx, prev_fy;
      int                   points;
      logic [63:0]          sum_land, sum_plan, sum_cross, sum_land_sq, sum_plan_sq;

      function new();
         errors = 0;
         min_corr = 0;
         prev_lx = 0; prev_ly = 0; prev_fx = 0; prev_fy = 0;
         points = 0;
         clear_sums();
      endfunction

      function void clear_sums();
         sum_land = 0; sum_plan = 0; sum_cross = 0; sum_land_sq = 0; sum_plan_sq = 0;
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      function logic [63:0] isqrt(logic [63:0] v);
         logic [63:0] r, bt;
         r = 0;
         bt = 64'h1 << 62;
         while (bt > v) bt = bt >> 2;
         while (bt != 0) begin
            if (v >= r + bt) begin
               v = v - (r + bt);
               r = (r >> 1) + bt;
            end else begin
               r = r >> 1;
            end
            bt = bt >> 2;
         end
         return r;
      endfunction

      function logic [63:0] step_len(longint ax, longint ay, longint bx, longint by);
         longint dx, dy;
         logic [63:0] ux, uy;
         dx = ax - bx;
         dy = ay - by;
         ux = (dx < 0) ? -dx : dx;
         uy = (dy < 0) ? -dy : dy;
         return isqrt(ux * ux + uy * uy);
      endfunction

      function void accumulate(inout logic [63:0] s, input logic [63:0] a,
                               input logic [63:0] lim, inout bit sat);
         logic [64:0] t;
         t = {1'b0, s} + a;
         if (t > {1'b0, lim}) begin
            sat = 1;
            s = lim;
         end else begin
            s = t[63:0];
         end
      endfunction

      function logic [63:0] root_scaled(logic [127:0] v, output int half);
         half = 0;
         while ((v >> 62) != 0) begin
            v = v >> 2;
            half++;
         end
         return isqrt(v[63:0]);
      endfunction

      function void correlate(output bit defined, output logic [15:0] value);
         logic [127:0] n, a1, a2, b1, b2, p, q, num, m, d;
         logic [63:0]  sa, sb, res;
         int           ja, jb, sh, b;
         bit           neg;
         n = points;
         a1 = n * sum_land_sq;
         a2 = sum_land * sum_land;
         b1 = n * sum_plan_sq;
         b2 = sum_plan * sum_plan;
         p = n * sum_cross;
         q = sum_land * sum_plan;
         defined = 0;
         value = 0;
         if (a1 <= a2 || b1 <= b2) return;
         defined = 1;
         sa = root_scaled(a1 - a2, ja);
         sb = root_scaled(b1 - b2, jb);
         neg = p < q;
         num = neg ? q - p : p - q;
         sh = ja + jb;
         m = (sh >= 14) ? num >> (sh - 14) : num << (14 - sh);
         d = sa * sb;
         res = 0;
         if (m >= (d << 15)) begin
            res = 16384;
         end else begin
            for (b = 14; b >= 0; b--) begin
               if (m >= (d << b)) begin
                  m = m - (d << b);
                  res[b] = 1'b1;
               end
            end
            if (res > 16384) res = 16384;
         end
         value = neg ? 16'(-res) : res[15:0];
      endfunction

      function void note(req_type r);
         longint      lx, ly, fx, fy;
         logic [63:0] dl, dp;
         bit          sat, defined;
         logic [15:0] value;
         rsp_type     e;
         lx = longint'(r.landmark_x);
         ly = longint'(r.landmark_y);
         fx = longint'(r.floor_x);
         fy = longint'(r.floor_y);
         sat = 0;
         if (!r.action || points == 0) begin
            points = 1;
            clear_sums();
            prev_lx = lx; prev_ly = ly; prev_fx = fx; prev_fy = fy;
         end else if (points >= MAX_POINTS) begin
            sat = 1;
         end else begin
            dl = step_len(lx, ly, prev_lx, prev_ly);
            dp = step_len(fx, fy, prev_fx, prev_fy);
            points++;
            accumulate(sum_land, dl, (64'h1 << 40) - 1, sat);
            accumulate(sum_plan, dp, (64'h1 << 40) - 1, sat);
            accumulate(sum_cross, dl * dp, '1, sat);
            accumulate(sum_land_sq, dl * dl, '1, sat);
            accumulate(sum_plan_sq, dp * dp, '1, sat);
            prev_lx = lx; prev_ly = ly; prev_fx = fx; prev_fy = fy;
         end
         correlate(defined, value);
         e.corr_value = value;
         e.corr_defined = defined;
         e.passes_threshold = defined && ($signed(value) >= min_corr);
         e.point_count = points[6:0];
         e.saturated = sat;
         expected_q = {expected_q, e};
      endfunction

      task check(rsp_type g);
         rsp_type e;
         if (expected_q.size() == 0) begin
            report($sformatf("result with none expected: %h", g));
            return;
         end
         e = expected_q.pop_front();
         if (g.corr_value !== e.corr_value)
            report($sformatf("corr_value %0d, expected %0d", g.corr_value, e.corr_value));
         if (g.corr_defined !== e.corr_defined)
            report($sformatf("corr_defined %b, expected %b", g.corr_defined, e.corr_defined));
         if (g.passes_threshold !== e.passes_threshold)
            report($sformatf("passes_threshold %b, expected %b",
                             g.passes_threshold, e.passes_threshold));
         if (g.point_count !== e.point_count)
            report($sformatf("point_count %0d, expected %0d", g.point_count, e.point_count));
         if (g.saturated !== e.saturated)
            report($sformatf("saturated %b, expected %b", g.saturated, e.saturated));
      endtask
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   rsp_type           rsp_data;
   logic              csr_wr_en;
   logic [CORR_W-1:0] csr_wr_data;

   corr_scoreboard sb = new();
   int     send_idle_pct = 0;
   int     stall_pct = 0;
   int     long_hold = 0;
   req_type last_req = '0;

   incremental_step_distance_correlation_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #(64'd80_000_000);
      $display("testbench NOT OK");
      $finish;
   end

   initial rsp_ready = 1'b0;

   // result side: check each transfer, then stall at random or hold off
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check(rsp_data);
      if (long_hold > 0) begin
         rsp_ready <= 1'b0;
         long_hold--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task send(input req_type r);
      req_valid <= 1'b1;
      req_data <= r;
      sb.note(r);
      last_req = r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task write_threshold(input logic signed [15:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.min_corr = v;
      @(posedge clock);
   endtask

   function req_type mk(logic act, int lx, int ly, int fx, int fy);
      req_type r;
      r.action = act;
      r.landmark_x = lx[19:0];
      r.landmark_y = ly[19:0];
      r.floor_x = fx[19:0];
      r.floor_y = fy[19:0];
      return r;
   endfunction

   function logic [19:0] move(logic [19:0] p);
      int sel;
      sel = $urandom_range(9);
      if (sel < 2) return 20'($urandom);
      if (sel < 6) return p + 20'(int'($urandom_range(2000)) - 1000);
      if (sel < 8) return p + 20'(int'($urandom_range(6)) - 3);
      return p;
   endfunction

   task run_items(input int target);
      int      sent, napp, i, sel;
      req_type r;
      sent = 0;
      while (sent < target) begin
         sel = $urandom_range(99);
         if (sel < 70) napp = $urandom_range(1, 8);
         else if (sel < 94) napp = $urandom_range(9, 30);
         else napp = $urandom_range(60, 75);
         r = mk(1'b0, $urandom, $urandom, $urandom, $urandom);
         if ($urandom_range(3) == 0) r = mk(1'b0, $urandom_range(2000), $urandom_range(2000),
                                            $urandom_range(2000), $urandom_range(2000));
         send(r);
         sent++;
         for (i = 0; i < napp && sent < target; i++) begin
            r.action = ($urandom_range(9) != 0);
            r.landmark_x = move(last_req.landmark_x);
            r.landmark_y = move(last_req.landmark_y);
            r.floor_x = move(last_req.floor_x);
            r.floor_y = move(last_req.floor_y);
            send(r);
            sent++;
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: append to an empty chain, extremes, zero steps, equal steps,
      // opposite trends, a restart inside a chain
      send(mk(1'b1, -524288, -524288, 524287, 524287));
      send(mk(1'b1, 524287, 524287, -524288, -524288));
      send(mk(1'b1, 524287, 524287, -524288, -524288));
      send(mk(1'b1, -524288, 524287, 524287, -524288));
      send(mk(1'b0, 0, 0, 0, 0));
      send(mk(1'b1, 3, 4, 3, 4));
      send(mk(1'b1, 6, 8, 6, 8));
      send(mk(1'b1, 9, 12, 9, 12));
      send(mk(1'b0, 0, 0, 0, 0));
      send(mk(1'b1, 10, 0, 100, 0));
      send(mk(1'b1, 30, 0, 150, 0));
      send(mk(1'b1, 70, 0, 170, 0));
      send(mk(1'b1, 150, 0, 175, 0));
      send(mk(1'b0, 0, 0, 0, 0));
      send(mk(1'b1, 5, 0, 5, 0));
      send(mk(1'b1, 20, 0, 20, 0));
      send(mk(1'b1, 22, 0, 22, 0));
      send(mk(1'b0, -1, -1, -1, -1));
      send(mk(1'b1, -1, -1, 0, 0));
      send(mk(1'b1, 0, 0, 7, 0));
      send(mk(1'b0, 524287, -524288, -524288, 524287));
      drain();

      write_threshold(-16384);
      send_idle_pct = 0; stall_pct = 0;
      run_items(160);
      drain();

      write_threshold(16384);
      send_idle_pct = 57; stall_pct = 0;
      run_items(160);
      drain();

      write_threshold(0);
      send_idle_pct = 0; stall_pct = 57;
      run_items(160);
      drain();

      write_threshold(16'(int'($urandom_range(32768)) - 16384));
      send_idle_pct = 21; stall_pct = 21;
      run_items(160);
      drain();

      // long receiver hold-off while items keep coming
      write_threshold(16'(int'($urandom_range(16384))));
      send_idle_pct = 0; stall_pct = 0;
      long_hold = 3000;
      run_items(40);
      drain();

      if (sb.errors == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire

[incremental_step_distance_correlation_core.f]
+incdir+src
src/isdc_pkg.sv
src/isdc_dp.sv
src/isdc_ctrl.sv
src/incremental_step_distance_correlation_core.sv
src/isdc_checker.sv
tb/testbench.sv
